// ----- design/tccs_pkg.sv -----
// Shared types, constants and helpers for the text console cursor/scroll block.
package tccs_pkg;

    // text geometry
    localparam int TEXT_SCALE  = 1;
    localparam int LINE_PIXELS = 8;
    localparam int SCROLL_SPAN = 240;

    localparam logic [9:0] CHAR_W   = 10'(6 * TEXT_SCALE);
    localparam logic [9:0] LINE_H   = 10'(8 * TEXT_SCALE);
    localparam logic [9:0] LINE_P   = 10'(LINE_PIXELS);
    localparam logic [9:0] SPAN     = 10'(SCROLL_SPAN);

    // default depth of the command queue
    localparam int QUEUE_DEPTH_DEF = 2;

    // character codes
    localparam logic [7:0] CHAR_NL = 8'd10;
    localparam logic [7:0] CHAR_CR = 8'd13;

    // result kinds
    localparam logic [1:0] KIND_ERASE  = 2'd0;
    localparam logic [1:0] KIND_SCROLL = 2'd1;
    localparam logic [1:0] KIND_DRAW   = 2'd2;

    // register indexes
    localparam logic [2:0] REG_LEFT_MARGIN   = 3'd0;
    localparam logic [2:0] REG_TOP_MARGIN    = 3'd1;
    localparam logic [2:0] REG_AREA_WIDTH    = 3'd2;
    localparam logic [2:0] REG_AREA_HEIGHT   = 3'd3;
    localparam logic [2:0] REG_PANEL_HEIGHT  = 3'd4;
    localparam logic [2:0] REG_CLIPPED       = 3'd5;
    localparam logic [2:0] REG_SCROLL_ENABLE = 3'd6;
    localparam logic [2:0] REG_BG_COLOR      = 3'd7;

    // configuration registers
    typedef struct packed {
        logic [8:0]  left_margin;
        logic [8:0]  top_margin;
        logic [8:0]  area_width;
        logic [8:0]  area_height;
        logic [8:0]  panel_height;
        logic        clipped;
        logic        scroll_enable;
        logic [15:0] bg_color;
    } t_cfg;

    // one classified character, as passed from front to back
    typedef struct packed {
        logic        erase_en;
        logic [8:0]  old_ss;
        logic [8:0]  new_ss;
        logic        draw_en;
        logic [8:0]  col;
        logic [8:0]  crow;
        logic [7:0]  glyph;
        logic [15:0] fg;
    } t_cmd;

    // queue status toward the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    // bottom limit of the text area, full width
    function automatic logic [9:0] bottom_limit(input t_cfg cfg);
        logic [9:0] lim;
        if (cfg.clipped) begin
            lim = {1'b0, cfg.area_height} + {1'b0, cfg.top_margin};
        end else begin
            lim = {1'b0, cfg.panel_height};
        end
        return lim;
    endfunction

endpackage

// ----- design/tccs_if.sv -----
// Valid/ready channel interfaces: character input, result output, register writes.
interface tccs_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  char_code;
    logic [15:0] fg_color;

    modport source (output valid, char_code, fg_color, input ready);
    modport sink   (input valid, char_code, fg_color, output ready);
endinterface

interface tccs_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [8:0]  pos_x;
    logic [8:0]  pos_y;
    logic [7:0]  glyph;
    logic [15:0] paint_color;
    logic        last;

    modport source (output valid, kind, pos_x, pos_y, glyph, paint_color, last,
                    input ready);
    modport sink   (input valid, kind, pos_x, pos_y, glyph, paint_color, last,
                    output ready);
endinterface

interface tccs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/tccs_front.sv -----
// Front end: accepts characters, updates cursor and scroll start, queues commands.
module tccs_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tccs_in_if.sink          i_in,
    input  tccs_pkg::t_cfg   i_cfg,
    input  tccs_pkg::t_q_stat i_q_stat,
    output logic             o_push,
    output tccs_pkg::t_cmd   o_cmd
);
    import tccs_pkg::*;

    logic [8:0] r_col, r_row, r_ss;
    logic [8:0] n_col, n_row, n_ss;

    logic       is_nl, is_cr, wrap, over, erase_en, draw_en, accept;
    logic [8:0] col_a, row_new, ss_next;
    logic [9:0] row, lim, ss_sum, ss_sub, row_sub;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;

    // classify the word and work out the new cursor
    always_comb begin
        is_nl   = (i_in.char_code == CHAR_NL);
        is_cr   = (i_in.char_code == CHAR_CR);
        lim     = bottom_limit(i_cfg);
        wrap    = ({1'b0, r_col} + CHAR_W) >
                  ({1'b0, i_cfg.left_margin} + {1'b0, i_cfg.area_width});
        col_a   = (is_nl || wrap) ? i_cfg.left_margin : r_col;
        row     = {1'b0, r_row} + ((is_nl || wrap) ? LINE_H : 10'd0);
        over    = (row >= lim);
        row_sub = row - LINE_H;
        row_new = over ? row_sub[8:0] : row[8:0];
        ss_sum  = {1'b0, r_ss} + LINE_P;
        ss_sub  = ss_sum - SPAN;
        ss_next = (ss_sum < SPAN) ? ss_sum[8:0] : ss_sub[8:0];
        draw_en  = !is_nl && !is_cr;
        erase_en = over && i_cfg.scroll_enable && !is_cr;
    end

    // next state
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_ss  = r_ss;
        if (accept && !is_cr) begin
            n_col = draw_en ? (col_a + CHAR_W[8:0]) : i_cfg.left_margin;
            n_row = row_new;
            if (erase_en) begin
                n_ss = ss_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_ss  <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_ss  <= n_ss;
        end
    end

    // command toward the back end
    assign o_push = accept && (erase_en || draw_en);
    always_comb begin
        o_cmd.erase_en = erase_en;
        o_cmd.old_ss   = r_ss;
        o_cmd.new_ss   = erase_en ? ss_next : r_ss;
        o_cmd.draw_en  = draw_en;
        o_cmd.col      = col_a;
        o_cmd.crow     = row_new;
        o_cmd.glyph    = i_in.char_code;
        o_cmd.fg       = i_in.fg_color;
    end

endmodule

// ----- design/tccs_queue.sv -----
// Short command queue between the front and back ends.
module tccs_queue #(
    parameter int DEPTH = tccs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tccs_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output tccs_pkg::t_cmd    o_head,
    output tccs_pkg::t_q_stat o_stat
);
    import tccs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == FULL_CNT);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd];

    // pointer and count update
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ----- design/tccs_back.sv -----
// Back end: expands each queued command into its erase, scroll and/or draw words.
module tccs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tccs_pkg::t_cfg    i_cfg,
    input  tccs_pkg::t_cmd    i_head,
    input  tccs_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    tccs_out_if.source        o_out
);
    import tccs_pkg::*;

    logic [1:0]  r_phase, n_phase;
    logic        r_valid;
    logic [1:0]  r_kind;
    logic [8:0]  r_x, r_y;
    logic [7:0]  r_glyph;
    logic [15:0] r_color;
    logic        r_last;

    logic        load, cur_last;
    logic [1:0]  cur_kind;
    logic [8:0]  cur_x, cur_y, mem_row;
    logic [7:0]  cur_glyph;
    logic [15:0] cur_color;
    logic [9:0]  lim, sum, sum_sub;

    assign load  = !i_q_stat.empty && (!r_valid || o_out.ready);
    assign o_pop = load && cur_last;

    // translate the cursor row into a memory row
    always_comb begin
        lim     = bottom_limit(i_cfg);
        sum     = {1'b0, i_head.new_ss} + {1'b0, i_head.crow};
        sum_sub = sum - lim;
        mem_row = (sum < lim) ? sum[8:0] : sum_sub[8:0];
    end

    // pick the word for the current phase
    always_comb begin
        if (i_head.erase_en && r_phase == 2'd0) begin
            cur_kind = KIND_ERASE;
        end else if (i_head.erase_en && r_phase == 2'd1) begin
            cur_kind = KIND_SCROLL;
        end else begin
            cur_kind = KIND_DRAW;
        end
        cur_x     = 9'd0;
        cur_glyph = 8'd0;
        cur_last  = 1'b0;
        case (cur_kind)
            KIND_ERASE: begin
                cur_y     = i_head.old_ss;
                cur_color = i_cfg.bg_color;
            end
            KIND_SCROLL: begin
                cur_y     = i_head.new_ss;
                cur_color = 16'd0;
                cur_last  = !i_head.draw_en;
            end
            default: begin
                cur_x     = i_head.col;
                cur_y     = mem_row;
                cur_glyph = i_head.glyph;
                cur_color = i_head.fg;
                cur_last  = 1'b1;
            end
        endcase
        n_phase = r_phase;
        if (load) begin
            n_phase = cur_last ? 2'd0 : r_phase + 2'd1;
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= cur_kind;
            r_x     <= cur_x;
            r_y     <= cur_y;
            r_glyph <= cur_glyph;
            r_color <= cur_color;
            r_last  <= cur_last;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_kind;
    assign o_out.pos_x       = r_x;
    assign o_out.pos_y       = r_y;
    assign o_out.glyph       = r_glyph;
    assign o_out.paint_color = r_color;
    assign o_out.last        = r_last;

endmodule

// ----- design/text_console_cursor_scroll_core.sv -----
// Text console cursor and hardware scroll core: registers, front, queue, back.
// An accepted character is queued first; its first word then loads the output register.
// One word per cycle leaves the single output register while o_out is ready; a character gives
// 0 to 3 words (none for CR or a quiet newline; draw; erase+scroll; erase+scroll+draw).
// Input is taken every cycle while the command queue has room.
// Reset (synchronous, active low): cursor, scroll start, queue, output cleared; regs to defaults.
module text_console_cursor_scroll_core #(
    parameter int QUEUE_DEPTH = tccs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tccs_in_if.sink    i_in,
    tccs_out_if.source o_out,
    tccs_cfg_if.sink   i_cfg
);
    import tccs_pkg::*;

    t_cfg    r_cfg;
    t_cmd    push_cmd, head;
    t_q_stat q_stat;
    logic    push, pop;

    assign i_cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_margin   <= 9'd0;
            r_cfg.top_margin    <= 9'd0;
            r_cfg.area_width    <= 9'd240;
            r_cfg.area_height   <= 9'd240;
            r_cfg.panel_height  <= 9'd320;
            r_cfg.clipped       <= 1'b0;
            r_cfg.scroll_enable <= 1'b1;
            r_cfg.bg_color      <= 16'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LEFT_MARGIN:   r_cfg.left_margin   <= i_cfg.data[8:0];
                REG_TOP_MARGIN:    r_cfg.top_margin    <= i_cfg.data[8:0];
                REG_AREA_WIDTH:    r_cfg.area_width    <= i_cfg.data[8:0];
                REG_AREA_HEIGHT:   r_cfg.area_height   <= i_cfg.data[8:0];
                REG_PANEL_HEIGHT:  r_cfg.panel_height  <= i_cfg.data[8:0];
                REG_CLIPPED:       r_cfg.clipped       <= i_cfg.data[0];
                REG_SCROLL_ENABLE: r_cfg.scroll_enable <= i_cfg.data[0];
                REG_BG_COLOR:      r_cfg.bg_color      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    tccs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    tccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tccs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule
